// ----- hdl/velocity_command_slew_limiter_unit_defines.svh -----
// assertion macros for the velocity command slew limiter
`ifndef VELOCITY_COMMAND_SLEW_LIMITER_UNIT_DEFINES_SVH
`define VELOCITY_COMMAND_SLEW_LIMITER_UNIT_DEFINES_SVH

// generic clocked assertion with reset disable
`define VCSL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define VCSL_ASSERT(label, prop, msg) \
  `VCSL_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/vcsl_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the velocity command slew limiter
package vcsl_pkg;

  localparam int LIM_W      = 23;
  localparam int TMO_W      = 14;
  localparam int COUNT_W    = 32;
  localparam int FAULT_W    = 16;
  localparam int OP_W       = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = LIM_W;

  localparam logic [LIM_W-1:0] RST_MAX_LIN_X = LIM_W'(314573);
  localparam logic [LIM_W-1:0] RST_MAX_LIN_Y = LIM_W'(0);
  localparam logic [LIM_W-1:0] RST_MAX_ANG_Z = LIM_W'(1258291);
  localparam logic [LIM_W-1:0] RST_LIN_STEP  = LIM_W'(2097);
  localparam logic [LIM_W-1:0] RST_YAW_STEP  = LIM_W'(4194);
  localparam logic [TMO_W-1:0] RST_TIMEOUT   = TMO_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_COMMAND    = 3'd0,
    OP_TICK       = 3'd1,
    OP_MOTORS_ON  = 3'd2,
    OP_MOTORS_OFF = 3'd3,
    OP_ESTOP      = 3'd4,
    OP_RELEASE    = 3'd5
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_LIN_X = 3'd0,
    CFG_MAX_LIN_Y = 3'd1,
    CFG_MAX_ANG_Z = 3'd2,
    CFG_LIN_STEP  = 3'd3,
    CFG_YAW_STEP  = 3'd4,
    CFG_TIMEOUT   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LIM_W-1:0] max_lin_x;
    logic [LIM_W-1:0] max_lin_y;
    logic [LIM_W-1:0] max_ang_z;
    logic [LIM_W-1:0] lin_step;
    logic [LIM_W-1:0] yaw_step;
    logic [TMO_W-1:0] timeout;
  } cfg_t;

endpackage

// ----- hdl/vcsl_cfg_regs.sv -----
`timescale 1ns / 1ps
// configuration register file for the slew limiter
module vcsl_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [vcsl_pkg::CFG_ADDR_W-1:0]  addr_i,
  input  logic [vcsl_pkg::CFG_DATA_W-1:0]  wdata_i,
  output vcsl_pkg::cfg_t                   cfg_o
);
  import vcsl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(addr_i))
        CFG_MAX_LIN_X: cfg_d.max_lin_x = wdata_i;
        CFG_MAX_LIN_Y: cfg_d.max_lin_y = wdata_i;
        CFG_MAX_ANG_Z: cfg_d.max_ang_z = wdata_i;
        CFG_LIN_STEP:  cfg_d.lin_step  = wdata_i;
        CFG_YAW_STEP:  cfg_d.yaw_step  = wdata_i;
        CFG_TIMEOUT:   cfg_d.timeout   = wdata_i[TMO_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_lin_x <= RST_MAX_LIN_X;
      cfg_q.max_lin_y <= RST_MAX_LIN_Y;
      cfg_q.max_ang_z <= RST_MAX_ANG_Z;
      cfg_q.lin_step  <= RST_LIN_STEP;
      cfg_q.yaw_step  <= RST_YAW_STEP;
      cfg_q.timeout   <= RST_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/vcsl_axis.sv -----
`timescale 1ns / 1ps
// per-axis clamp and slew limit
module vcsl_axis #(
  parameter int VEL_WIDTH  = 24,
  parameter int TICK_WIDTH = 24
) (
  input  logic signed [VEL_WIDTH-1:0]      target_i,
  input  logic signed [VEL_WIDTH-1:0]      prev_i,
  input  logic        [vcsl_pkg::LIM_W-1:0] lim_i,
  input  logic        [vcsl_pkg::LIM_W-1:0] step_i,
  input  logic        [TICK_WIDTH-1:0]     ticks_i,
  output logic signed [VEL_WIDTH-1:0]      next_o
);
  import vcsl_pkg::*;

  localparam int LW = ((VEL_WIDTH > LIM_W) ? VEL_WIDTH : LIM_W) + 2;
  localparam int RW = LIM_W + TICK_WIDTH;
  localparam int CW = ((RW > VEL_WIDTH + 1) ? RW : VEL_WIDTH + 1) + 2;
  localparam logic signed [LW-1:0] VMAX = LW'((64'd1 << (VEL_WIDTH - 1)) - 64'd1);

  logic signed [LW-1:0]        lim_raw, lim, v_ext, clamped;
  logic signed [VEL_WIDTH-1:0] tgt;
  logic        [RW-1:0]        room;
  logic signed [CW-1:0]        room_s, diff, diff_lim, sum;

  // clamp, limit reduced to the velocity range
  always_comb begin
    lim_raw = signed'(LW'(lim_i));
    lim     = (lim_raw > VMAX) ? VMAX : lim_raw;
    v_ext   = LW'(target_i);
    if (v_ext > lim) begin
      clamped = lim;
    end else if (v_ext < -lim) begin
      clamped = -lim;
    end else begin
      clamped = v_ext;
    end
    tgt = VEL_WIDTH'(clamped);
  end

  assign room = RW'(step_i) * RW'(ticks_i);

  // slew cap on the change from the last output
  always_comb begin
    room_s = signed'(CW'(room));
    diff   = CW'(tgt) - CW'(prev_i);
    if (diff > room_s) begin
      diff_lim = room_s;
    end else if (diff < -room_s) begin
      diff_lim = -room_s;
    end else begin
      diff_lim = diff;
    end
    sum    = CW'(prev_i) + diff_lim;
    next_o = VEL_WIDTH'(sum);
  end

endmodule

// ----- hdl/velocity_command_slew_limiter_unit.sv -----
`timescale 1ns / 1ps
// top level of the three-axis velocity command slew limiter
//
// usage
//   slave stream: tuser carries the op code, tdata carries cmd_vx, cmd_vy, cmd_wz.
//   master stream: one result beat per input beat, tuser is drive_update, tdata
//   carries the output velocities, flags and counts. the user must set limits,
//   steps and timeout via the write port only while idle; the block does not enforce it.
// timing
//   a beat is registered at the input, then processed in one pass of clamp,
//   one multiply and compare per axis into the output register; one beat per
//   cycle sustained while the receiver holds tready high. the multiply of step
//   by elapsed ticks sets the clock path.
// reset
//   asynchronous, active low: both stages empty, velocities, tick counter,
//   flags and counts cleared, registers at their defaults.
// stalls
//   while the receiver holds tready low the result beat is held; one further
//   beat waits in the input register, then tready on the slave side drops.
module velocity_command_slew_limiter_unit #(
  parameter int VEL_WIDTH  = 24,
  parameter int TICK_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // write port
  input  logic                                cfg_we_i,
  input  logic [vcsl_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [vcsl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cmd_vx, cmd_vy, cmd_wz, zero pad
  input  logic [((3*VEL_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // op
  input  logic [vcsl_pkg::OP_W-1:0]           s_axis_tuser,
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_vx, out_vy, out_wz, command_stale, estop_active, motors_on,
  // command_count, fault_count, zero pad
  output logic [((3*VEL_WIDTH+51+7)/8)*8-1:0] m_axis_tdata,
  // drive_update
  output logic                                m_axis_tuser
);
  import vcsl_pkg::*;

  localparam int OUT_W = ((3*VEL_WIDTH+51+7)/8)*8;
  localparam int TW    = (TICK_WIDTH > TMO_W) ? TICK_WIDTH : TMO_W;

  cfg_t cfg;

  logic                        in_valid_q, in_valid_d;
  logic [OP_W-1:0]             op_q;
  logic signed [VEL_WIDTH-1:0] vx_q, vy_q, wz_q;
  logic                        accept, advance;

  logic signed [VEL_WIDTH-1:0] last_vx_q, last_vx_d, last_vy_q, last_vy_d;
  logic signed [VEL_WIDTH-1:0] last_wz_q, last_wz_d;
  logic [TICK_WIDTH-1:0]       ticks_q, ticks_d, ticks_eff;
  logic                        motors_q, motors_d, stop_q, stop_d;
  logic [COUNT_W-1:0]          cmd_cnt_q, cmd_cnt_d;
  logic [FAULT_W-1:0]          fault_q, fault_d;

  logic signed [VEL_WIDTH-1:0] nx, ny, nz;
  logic signed [VEL_WIDTH-1:0] res_vx, res_vy, res_wz;
  logic                        upd, stale;

  logic                        out_valid_q, out_valid_d;
  logic signed [VEL_WIDTH-1:0] out_vx_q, out_vy_q, out_wz_q;
  logic                        out_upd_q, out_stale_q, out_estop_q, out_motors_q;
  logic [COUNT_W-1:0]          out_cnt_q;
  logic [FAULT_W-1:0]          out_fault_q;

  vcsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // input register
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= s_axis_tuser;
      vx_q <= signed'(s_axis_tdata[VEL_WIDTH-1:0]);
      vy_q <= signed'(s_axis_tdata[2*VEL_WIDTH-1:VEL_WIDTH]);
      wz_q <= signed'(s_axis_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH]);
    end
  end

  // axis units, floor of one tick
  assign ticks_eff = (ticks_q == '0) ? TICK_WIDTH'(1) : ticks_q;

  vcsl_axis #(.VEL_WIDTH(VEL_WIDTH), .TICK_WIDTH(TICK_WIDTH)) u_axis_x (
    .target_i (vx_q),
    .prev_i   (last_vx_q),
    .lim_i    (cfg.max_lin_x),
    .step_i   (cfg.lin_step),
    .ticks_i  (ticks_eff),
    .next_o   (nx)
  );

  vcsl_axis #(.VEL_WIDTH(VEL_WIDTH), .TICK_WIDTH(TICK_WIDTH)) u_axis_y (
    .target_i (vy_q),
    .prev_i   (last_vy_q),
    .lim_i    (cfg.max_lin_y),
    .step_i   (cfg.lin_step),
    .ticks_i  (ticks_eff),
    .next_o   (ny)
  );

  vcsl_axis #(.VEL_WIDTH(VEL_WIDTH), .TICK_WIDTH(TICK_WIDTH)) u_axis_z (
    .target_i (wz_q),
    .prev_i   (last_wz_q),
    .lim_i    (cfg.max_ang_z),
    .step_i   (cfg.yaw_step),
    .ticks_i  (ticks_eff),
    .next_o   (nz)
  );

  // op decode and state update
  always_comb begin
    last_vx_d = last_vx_q;
    last_vy_d = last_vy_q;
    last_wz_d = last_wz_q;
    ticks_d   = ticks_q;
    motors_d  = motors_q;
    stop_d    = stop_q;
    cmd_cnt_d = cmd_cnt_q;
    fault_d   = fault_q;
    res_vx    = '0;
    res_vy    = '0;
    res_wz    = '0;
    upd       = 1'b0;
    unique case (op_e'(op_q))
      OP_COMMAND: begin
        upd = 1'b1;
        if (!stop_q && motors_q) begin
          res_vx    = nx;
          res_vy    = ny;
          res_wz    = nz;
          last_vx_d = nx;
          last_vy_d = ny;
          last_wz_d = nz;
          ticks_d   = '0;
          cmd_cnt_d = cmd_cnt_q + COUNT_W'(1);
        end
      end
      OP_TICK: begin
        if (ticks_q != '1) begin
          ticks_d = ticks_q + TICK_WIDTH'(1);
        end
      end
      OP_MOTORS_ON: begin
        motors_d = 1'b1;
      end
      OP_MOTORS_OFF: begin
        motors_d = 1'b0;
        upd      = 1'b1;
      end
      OP_ESTOP: begin
        stop_d    = 1'b1;
        motors_d  = 1'b0;
        last_vx_d = '0;
        last_vy_d = '0;
        last_wz_d = '0;
        fault_d   = fault_q + FAULT_W'(1);
        upd       = 1'b1;
      end
      OP_RELEASE: begin
        stop_d = 1'b0;
      end
      default: begin
        upd = 1'b0;
      end
    endcase
    stale = TW'(ticks_d) > TW'(cfg.timeout);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vx_q <= '0;
      last_vy_q <= '0;
      last_wz_q <= '0;
      ticks_q   <= '0;
      motors_q  <= 1'b0;
      stop_q    <= 1'b0;
      cmd_cnt_q <= '0;
      fault_q   <= '0;
    end else if (advance) begin
      last_vx_q <= last_vx_d;
      last_vy_q <= last_vy_d;
      last_wz_q <= last_wz_d;
      ticks_q   <= ticks_d;
      motors_q  <= motors_d;
      stop_q    <= stop_d;
      cmd_cnt_q <= cmd_cnt_d;
      fault_q   <= fault_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_vx_q     <= res_vx;
      out_vy_q     <= res_vy;
      out_wz_q     <= res_wz;
      out_upd_q    <= upd;
      out_stale_q  <= stale;
      out_estop_q  <= stop_d;
      out_motors_q <= motors_d;
      out_cnt_q    <= cmd_cnt_d;
      out_fault_q  <= fault_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_upd_q;
  assign m_axis_tdata  = OUT_W'({out_fault_q, out_cnt_q, out_motors_q, out_estop_q,
                                 out_stale_q, out_wz_q, out_vy_q, out_vx_q});

endmodule

// ----- hdl/vcsl_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the slew limiter, bound to the top level
`include "velocity_command_slew_limiter_unit_defines.svh"

module vcsl_checker #(
  parameter int VEL_WIDTH = 24
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((3*VEL_WIDTH+51+7)/8)*8-1:0] m_axis_tdata,
  input logic                                m_axis_tuser
);

  localparam int VB = 3 * VEL_WIDTH;

  logic vel_zero;
  logic estop_bit;
  logic motors_bit;

  assign vel_zero   = (m_axis_tdata[VB-1:0] == '0);
  assign estop_bit  = m_axis_tdata[VB+1];
  assign motors_bit = m_axis_tdata[VB+2];

  // stalled result beat holds
  `VCSL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // no dispatch means zero velocities
  `VCSL_ASSERT(a_idle_zero, m_axis_tvalid && !m_axis_tuser |-> vel_zero, "velocity without drive update")

  // stopped or disabled gives zero velocities
  `VCSL_ASSERT(a_safe_zero, m_axis_tvalid && (estop_bit || !motors_bit) |-> vel_zero, "motion while stopped or disabled")

  // empty output stage never blocks the input
  `VCSL_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

endmodule

bind velocity_command_slew_limiter_unit vcsl_checker #(.VEL_WIDTH(VEL_WIDTH)) u_vcsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
